[hdl/m4vt_pkg.sv]
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared types and constants for the 4x4 fixed-point matrix-vector transform.
// ----------------------------------------------------------------------------
package m4vt_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_XFORM = 1'b1;

    localparam int VEC_LEN     = 4;
    localparam int WORD_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                                 xform;
        logic [1:0]                           column;
        logic [1:0]                           row;
        logic [WORD_W-1:0]                    value;
        logic [VEC_LEN-1:0][WORD_W-1:0]       vec;
    } t_item;

endpackage

[hdl/m4vt_front.sv]
// ----------------------------------------------------------------------------
// m4vt_front
// Input stage: registers transactions, drops out-of-range element writes.
// ----------------------------------------------------------------------------
module m4vt_front #(
    parameter int DIM = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_command,
    input  logic [1:0]          i_column,
    input  logic [1:0]          i_row,
    input  logic signed [31:0]  i_element_value,
    input  logic signed [31:0]  i_vec_x,
    input  logic signed [31:0]  i_vec_y,
    input  logic signed [31:0]  i_vec_z,
    input  logic signed [31:0]  i_vec_w,
    input  logic                i_full,
    output logic                o_push,
    output m4vt_pkg::t_item     o_item
);

    logic            r_valid;
    m4vt_pkg::t_item r_item;
    m4vt_pkg::t_item n_item;
    logic            keep;

    always_comb begin
        keep = (i_command == m4vt_pkg::CMD_XFORM) ||
               ((int'(i_column) < DIM) && (int'(i_row) < DIM));
        n_item.xform  = (i_command == m4vt_pkg::CMD_XFORM);
        n_item.column = i_column;
        n_item.row    = i_row;
        n_item.value  = i_element_value;
        n_item.vec[0] = i_vec_x;
        n_item.vec[1] = i_vec_y;
        n_item.vec[2] = i_vec_z;
        n_item.vec[3] = i_vec_w;
    end

    assign o_stall = r_valid && i_full;
    assign o_push  = r_valid && !i_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

[hdl/m4vt_queue.sv]
// ----------------------------------------------------------------------------
// m4vt_queue
// Short FIFO between the input stage and the datapath.
// ----------------------------------------------------------------------------
module m4vt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  m4vt_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output m4vt_pkg::t_item o_item
);

    m4vt_pkg::t_item                    r_mem [m4vt_pkg::QUEUE_DEPTH];
    logic [m4vt_pkg::QPTR_W-1:0]        r_wptr;
    logic [m4vt_pkg::QPTR_W-1:0]        r_rptr;
    logic [m4vt_pkg::QCNT_W-1:0]        r_count;
    logic [m4vt_pkg::QCNT_W-1:0]        n_count;
    logic                               do_pop;

    assign o_full  = (r_count == m4vt_pkg::QCNT_W'(m4vt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

[hdl/m4vt_back.sv]
// ----------------------------------------------------------------------------
// m4vt_back
// Matrix registers and the multiply / add / floor / saturate pipeline.
// ----------------------------------------------------------------------------
module m4vt_back #(
    parameter int FRAC_BITS = 16,
    parameter int DIM       = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  m4vt_pkg::t_item     i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_z,
    output logic signed [31:0]  o_out_w,
    output logic                o_saturated
);

    localparam int NU = (DIM < m4vt_pkg::VEC_LEN) ? DIM : m4vt_pkg::VEC_LEN;
    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    logic [31:0]        r_mat  [m4vt_pkg::VEC_LEN][m4vt_pkg::VEC_LEN];
    logic signed [63:0] r_prod [m4vt_pkg::VEC_LEN][m4vt_pkg::VEC_LEN];
    logic signed [64:0] r_pair [m4vt_pkg::VEC_LEN][2];
    logic signed [65:0] r_tot  [m4vt_pkg::VEC_LEN];
    logic signed [31:0] r_out  [m4vt_pkg::VEC_LEN];
    logic               r_sat;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               r_out_valid;

    logic               en;
    logic               do_xform;
    logic               do_write;
    logic signed [65:0] shifted [m4vt_pkg::VEC_LEN];
    logic signed [31:0] n_out   [m4vt_pkg::VEC_LEN];
    logic               n_sat;

    assign en       = !r_out_valid || !i_stall;
    assign o_pop    = i_valid && en;
    assign do_xform = o_pop && i_item.xform;
    assign do_write = o_pop && !i_item.xform;

    always_comb begin
        n_sat = 1'b0;
        for (int r = 0; r < m4vt_pkg::VEC_LEN; r++) begin
            shifted[r] = r_tot[r] >>> FRAC_BITS;
            if (shifted[r] > SAT_MAX) begin
                n_out[r] = 32'sh7fffffff;
                n_sat    = 1'b1;
            end else if (shifted[r] < SAT_MIN) begin
                n_out[r] = 32'sh80000000;
                n_sat    = 1'b1;
            end else begin
                n_out[r] = shifted[r][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < m4vt_pkg::VEC_LEN; c++) begin
                for (int r = 0; r < m4vt_pkg::VEC_LEN; r++) begin
                    r_mat[c][r] <= (c == r) ? ONE : 32'd0;
                end
            end
        end else if (en) begin
            r_v1        <= do_xform;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
            if (do_write) begin
                r_mat[i_item.column][i_item.row] <= i_item.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < m4vt_pkg::VEC_LEN; r++) begin
                for (int c = 0; c < m4vt_pkg::VEC_LEN; c++) begin
                    if (r < NU && c < NU) begin
                        r_prod[r][c] <= $signed(r_mat[c][r]) * $signed(i_item.vec[c]);
                    end else begin
                        r_prod[r][c] <= 64'sd0;
                    end
                end
                r_pair[r][0] <= 65'(r_prod[r][0]) + 65'(r_prod[r][1]);
                r_pair[r][1] <= 65'(r_prod[r][2]) + 65'(r_prod[r][3]);
                r_tot[r]     <= 66'(r_pair[r][0]) + 66'(r_pair[r][1]);
                r_out[r]     <= n_out[r];
            end
            r_sat <= n_sat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_x     = r_out[0];
    assign o_out_y     = r_out[1];
    assign o_out_z     = r_out[2];
    assign o_out_w     = r_out[3];
    assign o_saturated = r_sat;

endmodule

[hdl/matrix4_vector_transform.sv]
// A result passes the input, queue, product, pair-sum, total and output registers.
// One transaction/cycle unless stalled; a 4-entry queue decouples input from datapath.
// The datapath rate is set by 16 parallel 32x32 multipliers, one per matrix element.
// Element writes produce no result and apply to every transform accepted after them.
// Reset (synchronous, active low) empties the pipeline and loads the identity matrix.
// ----------------------------------------------------------------------------
// matrix4_vector_transform
// Signed Q16.16 4x4 matrix times vector, floored and saturated to 32 bits.
// ----------------------------------------------------------------------------
module matrix4_vector_transform #(
    parameter int FRAC_BITS = 16,
    parameter int DIM       = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_command,
    input  logic [1:0]          i_column,
    input  logic [1:0]          i_row,
    input  logic signed [31:0]  i_element_value,
    input  logic signed [31:0]  i_vec_x,
    input  logic signed [31:0]  i_vec_y,
    input  logic signed [31:0]  i_vec_z,
    input  logic signed [31:0]  i_vec_w,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_out_x,
    output logic signed [31:0]  o_out_y,
    output logic signed [31:0]  o_out_z,
    output logic signed [31:0]  o_out_w,
    output logic                o_saturated
);

    logic            push;
    logic            full;
    logic            q_valid;
    logic            pop;
    m4vt_pkg::t_item front_item;
    m4vt_pkg::t_item q_item;

    m4vt_front #(
        .DIM (DIM)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_column        (i_column),
        .i_row           (i_row),
        .i_element_value (i_element_value),
        .i_vec_x         (i_vec_x),
        .i_vec_y         (i_vec_y),
        .i_vec_z         (i_vec_z),
        .i_vec_w         (i_vec_w),
        .i_full          (full),
        .o_push          (push),
        .o_item          (front_item)
    );

    m4vt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (q_item)
    );

    m4vt_back #(
        .FRAC_BITS (FRAC_BITS),
        .DIM       (DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_z     (o_out_z),
        .o_out_w     (o_out_w),
        .o_saturated (o_saturated)
    );

endmodule

[hdl/m4vt_checker.sv]
// ----------------------------------------------------------------------------
// m4vt_checker
// Port-level checks for the matrix-vector transform, bound to the top level.
// ----------------------------------------------------------------------------
module m4vt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic signed [31:0]  o_out_x,
    input logic signed [31:0]  o_out_y,
    input logic signed [31:0]  o_out_z,
    input logic signed [31:0]  o_out_w,
    input logic                o_saturated
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_x) && $stable(o_out_y) &&
        $stable(o_out_z) && $stable(o_out_w) && $stable(o_saturated))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // a clamp flag must show at least one component at a range limit
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |->
            o_out_x == 32'sh7fffffff || o_out_x == 32'sh80000000 ||
            o_out_y == 32'sh7fffffff || o_out_y == 32'sh80000000 ||
            o_out_z == 32'sh7fffffff || o_out_z == 32'sh80000000 ||
            o_out_w == 32'sh7fffffff || o_out_w == 32'sh80000000)
        else $error("saturated set without clamped component");

endmodule

bind matrix4_vector_transform m4vt_checker u_m4vt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_x     (o_out_x),
    .o_out_y     (o_out_y),
    .o_out_z     (o_out_z),
    .o_out_w     (o_out_w),
    .o_saturated (o_saturated)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4x4 Q16.16 matrix-vector transform. Element
// writes update a shadow matrix and each accepted transform queues a
// predicted result (exact sum, floored, clamped), which is compared field
// by field against the output stream under random valid and stall gaps.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FRAC_BITS   = 16;
    localparam int DIM         = 4;
    localparam int TARGET      = 520;
    localparam int QUIET_TAIL  = 100;
    localparam int LONG_HOLD   = 80;
    localparam int SETTLE      = 16;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN = 32'h8000_0000;
    localparam logic [31:0] W_ONE = 32'h0001_0000;

    typedef struct packed {
        logic [3:0][31:0] comp;
        logic             sat;
    } t_vec_result;

    class transform_board;
        logic [31:0]  elem [DIM*DIM];
        t_vec_result  pending_results [$];
        int           mismatches;
        int           n_writes;
        int           n_xforms;
        int           n_sat;
        int           n_checked;

        function new();
            for (int c = 0; c < DIM; c++)
                for (int r = 0; r < DIM; r++)
                    elem[c*DIM + r] = (c == r) ? W_ONE : 32'h0;
        endfunction

        function t_vec_result predict_transform(input logic [3:0][31:0] v);
            t_vec_result        res;
            logic signed [67:0] acc;
            logic signed [67:0] flo;
            logic signed [63:0] prod;
            res = '0;
            for (int r = 0; r < 4; r++) begin
                if (r < DIM) begin
                    acc = '0;
                    for (int c = 0; c < DIM && c < 4; c++) begin
                        prod = $signed(elem[c*DIM + r]) * $signed(v[c]);
                        acc  = acc + prod;
                    end
                    flo = acc >>> FRAC_BITS;
                    if (flo > 68'sd2147483647) begin
                        res.comp[r] = W_MAX;
                        res.sat     = 1'b1;
                    end else if (flo < -68'sd2147483648) begin
                        res.comp[r] = W_MIN;
                        res.sat     = 1'b1;
                    end else begin
                        res.comp[r] = flo[31:0];
                    end
                end
            end
            return res;
        endfunction

        function void note_input(input logic cmd, input logic [1:0] col, input logic [1:0] row,
                                 input logic [31:0] val, input logic [3:0][31:0] vec);
            t_vec_result res;
            if (cmd == m4vt_pkg::CMD_WRITE) begin
                n_writes++;
                if (col < DIM && row < DIM)
                    elem[col*DIM + row] = val;
            end else begin
                res = predict_transform(vec);
                n_xforms++;
                if (res.sat)
                    n_sat++;
                pending_results.push_back(res);
            end
        endfunction

        function void flag(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch on %s: expected %h, got %h", $time, field, exp_v, act_v);
        endfunction

        function void check_result(input t_vec_result got);
            t_vec_result exp_r;
            string       names [4];
            names = '{"out_x", "out_y", "out_z", "out_w"};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result with nothing pending: %h", $time, got);
                return;
            end
            exp_r = pending_results.pop_front();
            n_checked++;
            for (int i = 0; i < 4; i++)
                if (got.comp[i] !== exp_r.comp[i])
                    flag(names[i], exp_r.comp[i], got.comp[i]);
            if (got.sat !== exp_r.sat)
                flag("saturated", {31'b0, exp_r.sat}, {31'b0, got.sat});
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_command = m4vt_pkg::CMD_WRITE;
    logic [1:0]         i_column = 2'd0;
    logic [1:0]         i_row = 2'd0;
    logic signed [31:0] i_element_value = '0;
    logic signed [31:0] i_vec_x = '0;
    logic signed [31:0] i_vec_y = '0;
    logic signed [31:0] i_vec_z = '0;
    logic signed [31:0] i_vec_w = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic signed [31:0] o_out_w;
    logic               o_saturated;

    transform_board board = new();
    bit             quiet = 1'b0;
    bit             hold_request = 1'b0;
    int             items_sent = 0;
    int             cycles = 0;

    matrix4_vector_transform #(
        .FRAC_BITS (FRAC_BITS),
        .DIM       (DIM)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_column        (i_column),
        .i_row           (i_row),
        .i_element_value (i_element_value),
        .i_vec_x         (i_vec_x),
        .i_vec_y         (i_vec_y),
        .i_vec_z         (i_vec_z),
        .i_vec_w         (i_vec_w),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_x         (o_out_x),
        .o_out_y         (o_out_y),
        .o_out_z         (o_out_z),
        .o_out_w         (o_out_w),
        .o_saturated     (o_saturated)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, board.pending());
            $display("matrix4_vector_transform regression: fail");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // transaction completes at the next rising edge
    always @(negedge i_clk) begin
        t_vec_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.comp = {o_out_w, o_out_z, o_out_y, o_out_x};
            got.sat  = o_saturated;
            board.check_result(got);
        end
    end

    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 6))
                    0:       w = W_MAX;
                    1:       w = W_MIN;
                    2:       w = 32'h0;
                    3:       w = 32'h1;
                    4:       w = 32'hFFFF_FFFF;
                    5:       w = W_ONE;
                    default: w = 32'hFFFF_0000;
                endcase
            end
            1, 2, 3, 4: begin
                w = $urandom_range(0, 32'h0004_0000);
                if ($urandom_range(0, 1))
                    w = -w;
            end
            default: w = $urandom();
        endcase
        return w;
    endfunction

    // called at a rising edge, returns at the edge where the transaction completes
    task automatic send_item(input logic cmd, input logic [1:0] col, input logic [1:0] row,
                             input logic [31:0] val, input logic [3:0][31:0] vec);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_command       <= cmd;
        i_column        <= col;
        i_row           <= row;
        i_element_value <= val;
        i_vec_x         <= vec[0];
        i_vec_y         <= vec[1];
        i_vec_z         <= vec[2];
        i_vec_w         <= vec[3];
        do @(negedge i_clk); while (o_stall);
        board.note_input(cmd, col, row, val, vec);
        items_sent++;
        @(posedge i_clk);
    endtask

    task automatic write_element(input logic [1:0] col, input logic [1:0] row,
                                 input logic [31:0] val);
        send_item(m4vt_pkg::CMD_WRITE, col, row, val,
                  {$urandom(), $urandom(), $urandom(), $urandom()});
    endtask

    task automatic transform_vec(input logic [31:0] x, input logic [31:0] y,
                                 input logic [31:0] z, input logic [31:0] w);
        send_item(m4vt_pkg::CMD_XFORM, 2'($urandom()), 2'($urandom()), $urandom(),
                  {w, z, y, x});
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // load part of the matrix, then stream vectors through it
    task automatic load_and_stream();
        repeat ($urandom_range(1, 16))
            write_element(2'($urandom()), 2'($urandom()), pick_word());
        repeat ($urandom_range(2, 10))
            transform_vec(pick_word(), pick_word(), pick_word(), pick_word());
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 6))
            send_item(1'($urandom()), 2'($urandom()), 2'($urandom()), $urandom(),
                      {$urandom(), $urandom(), $urandom(), $urandom()});
    endtask

    initial begin
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity passes extremes straight through
        transform_vec(W_ONE, 32'hFFFF_0000, W_MAX, W_MIN);
        transform_vec(32'h1, 32'hFFFF_FFFF, 32'h0, 32'h0);
        write_element(2'd0, 2'd0, W_MAX);
        write_element(2'd3, 2'd3, W_MIN);
        write_element(2'd2, 2'd1, 32'h1);
        write_element(2'd1, 2'd2, 32'hFFFF_FFFF);
        transform_vec(W_MAX, W_MIN, W_MAX, W_MIN);
        transform_vec(W_MIN, 32'h0, 32'h1, 32'hFFFF_FFFF);
        // negative sub-LSB results floor to -1
        transform_vec(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
        // two half-LSB products sum to one LSB only if floored together
        write_element(2'd0, 2'd1, 32'h0000_8000);
        write_element(2'd1, 2'd1, 32'h0000_8000);
        transform_vec(32'h1, 32'h1, 32'h0, 32'h0);
        // full-width row sum beyond 64 bits, and near cancellation of large products
        write_element(2'd0, 2'd0, W_MIN);
        write_element(2'd1, 2'd0, W_MIN);
        write_element(2'd2, 2'd0, W_MIN);
        write_element(2'd3, 2'd0, W_MIN);
        transform_vec(W_MIN, W_MIN, W_MIN, W_MIN);
        transform_vec(W_MIN, W_MAX, 32'h0, 32'h0);

        while (items_sent < TARGET) begin
            if (!hold_done && items_sent >= 150) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && items_sent >= 300) begin
                drain_results();
                pause_done = 1'b1;
            end
            if (items_sent >= TARGET - QUIET_TAIL)
                quiet = 1'b1;
            if ($urandom_range(0, 3) != 0)
                load_and_stream();
            else
                noise_burst();
        end

        drain_results();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d transactions: %0d element writes, %0d transforms (%0d clamped)",
                 items_sent, board.n_writes, board.n_xforms, board.n_sat);
        $display("checked %0d results, %0d mismatches", board.n_checked, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("matrix4_vector_transform regression: pass");
        end else begin
            $display("matrix4_vector_transform regression: fail");
        end
        $finish;
    end

endmodule
